@@ sv/rafl_pkg.sv @@
// ----------------------------------------------------------------------------
// rafl_pkg
// Shared types and constants of the free-range allocator.
// ----------------------------------------------------------------------------
package rafl_pkg;

  localparam int MAX_RANGES = 16;
  localparam int ADDR_BITS = 32;
  localparam int IDX_BITS = $clog2(MAX_RANGES);
  localparam int CNT_BITS = $clog2(MAX_RANGES + 1);

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [IDX_BITS-1:0] idx_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  localparam addr_t ADDR_ONES = '1;

  typedef enum logic [1:0] {
    CMD_FIRST_FIT = 2'd0,
    CMD_AT_ADDR   = 2'd1,
    CMD_FREE      = 2'd2,
    CMD_REINIT    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_BADLEN = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  localparam logic REG_POOL_BASE = 1'b0;
  localparam logic REG_POOL_LENGTH = 1'b1;

  // table edit request from the sequencer to the table
  typedef struct packed {
    logic  wr;        // write entry at idx
    idx_t  idx;
    addr_t base;
    addr_t len;
    logic  shift_up;  // move entry idx-1 into idx
    logic  shift_dn;  // move entry idx+1 into idx
    logic  clr;       // zero entry idx
    logic  load;      // reload from pool
  } tbl_op_t;

endpackage

@@ sv/rafl_table.sv @@
// ----------------------------------------------------------------------------
// rafl_table
// Free-range table: base/length memories, one entry a cycle, all on reload.
// ----------------------------------------------------------------------------
module rafl_table import rafl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  tbl_op_t op,
  input  idx_t    rd_idx,
  input  addr_t   pool_base,
  input  addr_t   pool_length,
  output addr_t   rd_base,
  output addr_t   rd_len
);

  addr_t base_q [MAX_RANGES];
  addr_t len_q  [MAX_RANGES];

  // single write per cycle, all entries on reset/load; shifts copy a neighbor
  always_ff @(posedge clk) begin
    if (rst || op.load) begin
      for (int k = 0; k < MAX_RANGES; k++) begin
        base_q[k] <= '0;
        len_q[k] <= '0;
      end
      if (rst) begin
        len_q[0] <= addr_t'(16'hFFFF);
      end else if (pool_length != '0) begin
        base_q[0] <= pool_base;
        len_q[0] <= pool_length;
      end
    end else if (op.clr) begin
      base_q[op.idx] <= '0;
      len_q[op.idx] <= '0;
    end else if (op.shift_up) begin
      base_q[op.idx] <= base_q[op.idx - idx_t'(1)];
      len_q[op.idx] <= len_q[op.idx - idx_t'(1)];
    end else if (op.shift_dn) begin
      base_q[op.idx] <= base_q[op.idx + idx_t'(1)];
      len_q[op.idx] <= len_q[op.idx + idx_t'(1)];
    end else if (op.wr) begin
      base_q[op.idx] <= op.base;
      len_q[op.idx] <= op.len;
    end
  end

  assign rd_base = base_q[rd_idx];
  assign rd_len = len_q[rd_idx];

endmodule

@@ sv/range_allocator_free_list_core.sv @@
// ----------------------------------------------------------------------------
// range_allocator_free_list_core
// First-fit and at-address range allocator over a sorted free-range table.
// ----------------------------------------------------------------------------
// Usage: commands enter on the s_axis channel (tdata holds command, address,
// length, align_mask, lower_bound; tuser the three flags). One result
// leaves on m_axis per command. The user writes the pool registers over
// cfg_we/cfg_index/cfg_data while the block is idle; it is not enforced.
// Sequence: after accepting a command the sequencer walks table entries,
// moves or clears entries to open or close a slot, and does a merge
// check or the final entry write; it reads one table entry a cycle.
// The block is ready again in the same cycle as the result appears.
// A reinitialize, a rejected length or a command on an empty table
// goes straight from idle to the result.
// The block takes one command at a time; s_axis_tready is high only while
// the sequencer is idle. The result sits in an output register until taken,
// and the next command is accepted while it waits; a new result is not
// written until the old one has gone.
// Reset loads the table with base 0, length 65535, and the pool registers
// with the same values.
// ----------------------------------------------------------------------------
module range_allocator_free_list_core import rafl_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[1:0], address[33:2], length[65:34], align_mask[97:66],
  // lower_bound[129:98], zero fill
  input  logic [135:0] s_axis_tdata,
  // align_to_size[0], require_pow2[1], bounded[2]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], granted_address[33:2], granted_length[65:34], zero fill
  output logic [71:0]  m_axis_tdata
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_INS   = 7'b0000100,
    S_DROP  = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_CHECK = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  addr_t pool_base, pool_length;
  cmd_t cmd;
  addr_t addr, len, mask, lower;
  logic bounded;
  cnt_t count;
  idx_t idx, tgt;
  status_t st;
  addr_t gb;
  // pending entry write after a shift
  addr_t pb, pl, wb2, wl2;
  logic w2;
  tbl_op_t op;
  addr_t rb, rl;
  logic out_valid;
  logic [71:0] out_data;

  rafl_table u_table (
    .clk(clk), .rst(rst), .op(op), .rd_idx(idx),
    .pool_base(pool_base), .pool_length(pool_length),
    .rd_base(rb), .rd_len(rl)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      pool_length <= addr_t'(16'hFFFF);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POOL_BASE:   pool_base <= cfg_data;
        REG_POOL_LENGTH: pool_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // decoded input
  logic in_acc;
  cmd_t in_cmd;
  addr_t in_len, in_mask;
  logic in_pow2chk, in_pow2ok;
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign in_cmd = cmd_t'(s_axis_tdata[1:0]);
  assign in_len = s_axis_tdata[65:34];
  assign in_pow2chk = s_axis_tuser[0] || s_axis_tuser[1];
  assign in_pow2ok = ((in_len & (in_len - addr_t'(1))) == '0);
  assign in_mask = s_axis_tuser[0] ? in_len - addr_t'(1) : s_axis_tdata[97:66];

  // per-entry evaluation on the read port (shared compare unit)
  addr_t eb, rup, off, ei, nend, after;
  logic rup_ovf, ff_fit, last;
  always_comb begin
    eb = (rb < lower) ? lower : rb;
    rup = (eb & ~mask) + mask + addr_t'(1);
    rup_ovf = ((eb & mask) != '0) && (rup <= eb);
    if ((eb & mask) != '0) eb = rup;
    off = eb - rb;
    ff_fit = !rup_ovf && (off <= rl) && (len <= rl - off);
    ei = rb + rl;
    nend = addr + len;
    after = rl - (addr - rb) - len;
    last = (cnt_t'(idx) + cnt_t'(1) >= count);
  end

  logic full;
  assign full = (count >= cnt_t'(MAX_RANGES));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= cnt_t'(1);
      out_valid <= 1'b0;
      idx <= '0;
      op <= '0;
    end else begin
      op <= '0;
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            cmd <= in_cmd;
            addr <= s_axis_tdata[33:2];
            len <= in_len;
            mask <= in_mask;
            bounded <= s_axis_tuser[2];
            lower <= s_axis_tuser[2] ? s_axis_tdata[129:98] : '0;
            idx <= '0;
            gb <= '0;
            st <= ST_NOFIT;
            w2 <= 1'b0;
            if (in_cmd == CMD_REINIT) begin
              op.load <= 1'b1;
              count <= (pool_length != '0) ? cnt_t'(1) : '0;
              st <= ST_OK;
              state <= S_DONE;
            end else if (in_len == '0 ||
                         (in_cmd != CMD_FREE && in_pow2chk && !in_pow2ok)) begin
              st <= ST_BADLEN;
              state <= S_DONE;
            end else if (count == '0) begin
              if (in_cmd == CMD_FREE) begin
                op.wr <= 1'b1;
                op.idx <= '0;
                op.base <= s_axis_tdata[33:2];
                op.len <= in_len;
                count <= cnt_t'(1);
                st <= ST_OK;
              end
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          state <= S_DONE;
          case (cmd)
            CMD_FIRST_FIT: begin
              if (ff_fit) begin
                gb <= eb;
                if (off == '0) begin
                  if (rl == len) begin
                    st <= ST_OK;
                    tgt <= idx;
                    state <= S_DROP;
                  end else begin
                    op.wr <= 1'b1; op.idx <= idx;
                    op.base <= rb + len; op.len <= rl - len;
                    st <= ST_OK;
                  end
                end else if (rl - off == len) begin
                  op.wr <= 1'b1; op.idx <= idx; op.base <= rb; op.len <= off;
                  st <= ST_OK;
                end else if (full) begin
                  st <= ST_FULL;
                end else begin
                  st <= ST_OK;
                  op.wr <= 1'b1; op.idx <= idx; op.base <= rb; op.len <= off;
                  pb <= eb + len; pl <= rl - off - len;
                  tgt <= idx + idx_t'(1);
                  idx <= idx_t'(count);
                  count <= count + cnt_t'(1);
                  state <= S_INS;
                end
              end else if (!last) begin
                idx <= idx + idx_t'(1);
                state <= S_SCAN;
              end
            end
            CMD_AT_ADDR: begin
              if ((bounded && lower > rb && lower - rb > rl) ||
                  addr < rb || addr - rb >= rl) begin
                if (!last) begin
                  idx <= idx + idx_t'(1);
                  state <= S_SCAN;
                end
              end else if (len > rl - (addr - rb)) begin
                st <= ST_NOFIT;
              end else begin
                gb <= addr;
                if (addr == rb) begin
                  if (rl == len) begin
                    st <= ST_OK; tgt <= idx; state <= S_DROP;
                  end else begin
                    op.wr <= 1'b1; op.idx <= idx;
                    op.base <= rb + len; op.len <= rl - len;
                    st <= ST_OK;
                  end
                end else if (after == '0) begin
                  op.wr <= 1'b1; op.idx <= idx; op.base <= rb; op.len <= addr - rb;
                  st <= ST_OK;
                end else if (full) begin
                  st <= ST_FULL;
                end else begin
                  st <= ST_OK;
                  op.wr <= 1'b1; op.idx <= idx; op.base <= rb; op.len <= addr - rb;
                  pb <= nend; pl <= after;
                  tgt <= idx + idx_t'(1);
                  idx <= idx_t'(count);
                  count <= count + cnt_t'(1);
                  state <= S_INS;
                end
              end
            end
            default: begin
              // free
              if (nend == rb) begin
                if (len > ADDR_ONES - rl) st <= ST_BADLEN;
                else begin
                  op.wr <= 1'b1; op.idx <= idx; op.base <= addr; op.len <= rl + len;
                  st <= ST_OK;
                end
              end else if (addr == ei) begin
                if (len > ADDR_ONES - rl) st <= ST_BADLEN;
                else begin
                  pb <= rb; pl <= rl + len; tgt <= idx;
                  if (!last) begin
                    idx <= idx + idx_t'(1);
                    state <= S_CHECK;
                  end else begin
                    op.wr <= 1'b1; op.idx <= idx; op.base <= rb; op.len <= rl + len;
                    st <= ST_OK;
                  end
                end
              end else if (addr < rb) begin
                if (full) st <= ST_FULL;
                else begin
                  st <= ST_OK; pb <= addr; pl <= len; tgt <= idx;
                  idx <= idx_t'(count);
                  count <= count + cnt_t'(1);
                  state <= S_INS;
                end
              end else if (!last) begin
                idx <= idx + idx_t'(1);
                state <= S_SCAN;
              end else if (full) begin
                st <= ST_FULL;
              end else begin
                st <= ST_OK;
                op.wr <= 1'b1; op.idx <= idx_t'(count);
                op.base <= addr; op.len <= len;
                count <= count + cnt_t'(1);
              end
            end
          endcase
        end
        // merge with next entry when the freed range also touches it
        S_CHECK: begin
          st <= ST_OK;
          state <= S_DONE;
          if (nend == rb) begin
            if (rl > ADDR_ONES - pl) begin
              st <= ST_BADLEN;
            end else begin
              wb2 <= pb; wl2 <= pl + rl; w2 <= 1'b1;
              state <= S_DROP;
              tgt <= idx;
            end
          end else begin
            op.wr <= 1'b1; op.idx <= tgt; op.base <= pb; op.len <= pl;
          end
        end
        // open a slot at tgt by moving entries up, idx walks down
        S_INS: begin
          if (idx == tgt) begin
            op.wr <= 1'b1; op.idx <= idx; op.base <= pb; op.len <= pl;
            state <= S_DONE;
          end else begin
            op.shift_up <= 1'b1; op.idx <= idx;
            idx <= idx - idx_t'(1);
          end
        end
        // close slot tgt by moving entries down, then clear the top
        S_DROP: begin
          if (cnt_t'(tgt) + cnt_t'(1) >= count) begin
            op.clr <= 1'b1; op.idx <= tgt;
            count <= count - cnt_t'(1);
            state <= w2 ? S_WRITE : S_DONE;
          end else begin
            op.shift_dn <= 1'b1; op.idx <= tgt;
            tgt <= tgt + idx_t'(1);
          end
        end
        S_WRITE: begin
          op.wr <= 1'b1; op.idx <= idx - idx_t'(1); op.base <= wb2; op.len <= wl2;
          state <= S_DONE;
        end
        default: begin
          // S_DONE: hand the result to the output register
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || m_axis_tready)) begin
      out_data <= '0;
      out_data[1:0] <= st;
      if (st == ST_OK && (cmd == CMD_FIRST_FIT || cmd == CMD_AT_ADDR)) begin
        out_data[33:2] <= gb;
        out_data[65:34] <= len;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_data;

endmodule

@@ sv/rafl_checker.sv @@
// ----------------------------------------------------------------------------
// rafl_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module rafl_checker import rafl_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [71:0]  m_axis_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no command is taken in the cycle after one was taken
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("back to back accept");

  // a failed status carries no grant
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[65:2] == '0)
    else $error("grant on failure");

  // zero fill stays zero
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[71:66] == '0)
    else $error("fill bits set");

endmodule

bind range_allocator_free_list_core rafl_checker u_rafl_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
